// ===== hw/rtl/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the rectangular polygon clipper: word
// formats of the vertex, result and register write channels.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int CoordW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCornerAX = 3'd0,
    CfgCornerAY = 3'd1,
    CfgCornerBX = 3'd2,
    CfgCornerBY = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } vertex_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   last_out;
    logic   empty_res;
    logic   overflow;
  } result_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

endpackage

// ===== hw/rtl/rect_polygon_clipper_core.sv =====
// ----------------------------------------------------------------------------
// rect_polygon_clipper_core
// Sutherland-Hodgman clipping of a polygon against an axis-aligned window,
// four passes over on-chip point memories with a shared multiplier and a
// bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  in        input      in_valid_i/in_ready_o  rpc_pkg::vertex_in_t
//  out       output     out_valid_o/out_ready_i rpc_pkg::result_t
//  cfg       input      cfg_valid_i/cfg_ready_o index + 16-bit data
//
//  a vertex that is not last is taken without leaving the idle state
//  each pass loads its first point at its start and sets the new point count at its end,
//  then per edge fetches the next point, evaluates the edge and writes the points it keeps;
//  an intersection that needs a divide adds multiply steps, setup, 35 divide steps, finish
//  results go out one word at a time, each read from memory, then loaded when the output slot is free
//  reset clears all registers but the point memories and their read registers, which need no clearing
//  in_ready_o is low from the last vertex until the final word is loaded
// ----------------------------------------------------------------------------
module rect_polygon_clipper_core #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_OUT      = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rpc_pkg::vertex_in_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rpc_pkg::result_t              out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int OAW  = $clog2(MAX_OUT);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);
  localparam int NCW  = $clog2(MAX_OUT + 1);
  localparam int CW   = rpc_pkg::CoordW;
  localparam int MW   = CW + 1;
  localparam int PW   = 2 * MW;
  localparam int NUMW = 2 * CW + 3;
  localparam int DCW  = $clog2(NUMW + 1);

  typedef enum logic [4:0] {
    StIdle, StPStart, StPRd0, StPFirst, StEFetch, StERd, StEWait, StEEval,
    StMul, StDivInit, StDiv, StDivFin, StPutIp, StPutT, StENext, StPEnd,
    StOStart, StORd, StOWait
  } state_e;

  state_e state_q;

  rpc_pkg::coord_t cax_q, cay_q, cbx_q, cby_q;
  logic [VCW-1:0]  vcount_q;
  logic            in_ovf_q;
  logic            ovf_q;
  logic [1:0]      pass_q;
  logic [NCW-1:0]  n_q, cnt_q, idx_q, rd_idx_q;
  rpc_pkg::point_t first_q, s_q, t_q;
  rpc_pkg::coord_t e_q, ip_o_q;
  logic            emit_t_q;
  logic [1:0]      mstep_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [NUMW-1:0] acc_q;
  logic [NUMW-1:0] dvd_q;
  logic [MW-1:0]   rem_q, dvs_q;
  logic            neg_q;
  logic [DCW-1:0]  dcnt_q;
  logic            out_valid_q;
  rpc_pkg::result_t out_q;

  rpc_pkg::point_t vs_mem [MAX_VERTICES];
  rpc_pkg::point_t a_mem  [MAX_OUT];
  rpc_pkg::point_t b_mem  [MAX_OUT];
  rpc_pkg::point_t vs_rd_q, a_rd_q, b_rd_q;

  // memory control
  logic            vs_we, a_we, b_we;
  rpc_pkg::point_t wr_pt;

  // input side
  logic            in_acc;
  logic [VCW-1:0]  vc_new;
  logic [NCW-1:0]  n_init;

  // output side
  logic            out_load;

  // edge datapath
  rpc_pkg::point_t src_pt;
  logic            axis, high;
  rpc_pkg::coord_t s_a, s_o, t_a, t_o;
  logic signed [MW-1:0] ds, dt, den;
  logic            s_out, t_in;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  rpc_pkg::coord_t xl, xr, yb, yt, e_sel;
  logic            slot_free;
  logic            can_put;
  logic [MW:0]     trial;
  logic            qbit;
  logic [NUMW-1:0] acc_mag;
  logic signed [MW-1:0] den_q_s;
  rpc_pkg::coord_t q_sat;
  rpc_pkg::point_t ip_pt;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_load    = slot_free & (((state_q == StOStart) && (n_q == '0))
                                    || (state_q == StOWait));

  assign vc_new = (int'(vcount_q) < MAX_VERTICES) ? vcount_q + 1'b1 : vcount_q;
  assign n_init = (int'(vc_new) > MAX_OUT) ? NCW'(MAX_OUT) : NCW'(vc_new);

  assign xl = (cax_q < cbx_q) ? cax_q : cbx_q;
  assign xr = (cax_q < cbx_q) ? cbx_q : cax_q;
  assign yb = (cay_q < cby_q) ? cay_q : cby_q;
  assign yt = (cay_q < cby_q) ? cby_q : cay_q;

  always_comb begin
    case (pass_q)
      2'd0:    e_sel = xl;
      2'd1:    e_sel = xr;
      2'd2:    e_sel = yb;
      default: e_sel = yt;
    endcase
  end

  always_comb begin
    case (pass_q)
      2'd0:    src_pt = vs_rd_q;
      2'd2:    src_pt = a_rd_q;
      default: src_pt = b_rd_q;
    endcase
    if (state_q == StOWait) begin
      src_pt = a_rd_q;
    end
  end

  assign axis = pass_q[1];
  assign high = pass_q[0];
  assign s_a  = axis ? s_q.y : s_q.x;
  assign s_o  = axis ? s_q.x : s_q.y;
  assign t_a  = axis ? t_q.y : t_q.x;
  assign t_o  = axis ? t_q.x : t_q.y;

  assign ds = high ? (MW'(e_q) - MW'(s_a)) : (MW'(s_a) - MW'(e_q));
  assign dt = high ? (MW'(e_q) - MW'(t_a)) : (MW'(t_a) - MW'(e_q));
  assign den = MW'(s_a) - MW'(t_a);
  assign s_out = ds < 0;
  assign t_in  = dt > 0;

  always_comb begin
    case (mstep_q)
      2'd0:    begin mul_a = MW'(s_a); mul_b = MW'(t_o); end
      2'd1:    begin mul_a = MW'(s_o); mul_b = MW'(t_a); end
      default: begin mul_a = MW'(s_o) - MW'(t_o); mul_b = MW'(e_q); end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign acc_mag = acc_q[NUMW-1] ? NUMW'(-acc_q) : NUMW'(acc_q);
  assign den_q_s = den;
  assign trial   = {rem_q, dvd_q[NUMW-1]};
  assign qbit    = trial >= {1'b0, dvs_q};

  always_comb begin
    if (neg_q) begin
      q_sat = (dvd_q > NUMW'(32768)) ? rpc_pkg::coord_t'(16'sh8000)
                                     : rpc_pkg::coord_t'(-dvd_q);
    end else begin
      q_sat = (dvd_q > NUMW'(32767)) ? rpc_pkg::coord_t'(16'sh7fff)
                                     : rpc_pkg::coord_t'(dvd_q);
    end
  end

  assign ip_pt.x = axis ? ip_o_q : e_q;
  assign ip_pt.y = axis ? e_q : ip_o_q;

  assign can_put = int'(cnt_q) < MAX_OUT;
  assign wr_pt   = (state_q == StPutIp) ? ip_pt : t_q;
  assign vs_we   = in_acc & (int'(vcount_q) < MAX_VERTICES);
  assign a_we    = (state_q == StPutIp || state_q == StPutT) && can_put && pass_q[0];
  assign b_we    = (state_q == StPutIp || state_q == StPutT) && can_put && !pass_q[0];

  always_ff @(posedge clk_i) begin
    if (vs_we) begin
      vs_mem[VAW'(vcount_q)] <= '{x: in_data_i.vertex_x, y: in_data_i.vertex_y};
    end
    vs_rd_q <= vs_mem[VAW'(rd_idx_q)];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[OAW'(cnt_q)] <= wr_pt;
    end
    a_rd_q <= a_mem[OAW'(rd_idx_q)];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[OAW'(cnt_q)] <= wr_pt;
    end
    b_rd_q <= b_mem[OAW'(rd_idx_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cax_q       <= '0;
      cay_q       <= '0;
      cbx_q       <= '0;
      cby_q       <= '0;
      vcount_q    <= '0;
      in_ovf_q    <= 1'b0;
      ovf_q       <= 1'b0;
      pass_q      <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_idx_q    <= '0;
      first_q     <= '0;
      s_q         <= '0;
      t_q         <= '0;
      e_q         <= '0;
      ip_o_q      <= '0;
      emit_t_q    <= 1'b0;
      mstep_q     <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      neg_q       <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rpc_pkg::CfgCornerAX: cax_q <= cfg_data_i;
          rpc_pkg::CfgCornerAY: cay_q <= cfg_data_i;
          rpc_pkg::CfgCornerBX: cbx_q <= cfg_data_i;
          rpc_pkg::CfgCornerBY: cby_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (in_data_i.last_vertex) begin
              n_q      <= n_init;
              ovf_q    <= in_ovf_q | (int'(vcount_q) >= MAX_VERTICES)
                          | (int'(vc_new) > MAX_OUT);
              pass_q   <= '0;
              vcount_q <= '0;
              in_ovf_q <= 1'b0;
              state_q  <= StPStart;
            end else begin
              vcount_q <= vc_new;
              if (int'(vcount_q) >= MAX_VERTICES) begin
                in_ovf_q <= 1'b1;
              end
            end
          end
        end
        StPStart: begin
          e_q      <= e_sel;
          cnt_q    <= '0;
          idx_q    <= '0;
          rd_idx_q <= '0;
          state_q  <= (n_q == '0) ? StPEnd : StPRd0;
        end
        StPRd0: state_q <= StPFirst;
        StPFirst: begin
          first_q <= src_pt;
          s_q     <= src_pt;
          state_q <= StEFetch;
        end
        StEFetch: begin
          if ({1'b0, idx_q} + 1'b1 < {1'b0, n_q}) begin
            rd_idx_q <= idx_q + 1'b1;
            state_q  <= StERd;
          end else begin
            t_q     <= first_q;
            state_q <= StEEval;
          end
        end
        StERd: state_q <= StEWait;
        StEWait: begin
          t_q     <= src_pt;
          state_q <= StEEval;
        end
        StEEval: begin
          emit_t_q <= t_in;
          mstep_q  <= '0;
          if (s_out == t_in) begin
            if (den == '0) begin
              ip_o_q  <= s_o;
              state_q <= StPutIp;
            end else begin
              state_q <= StMul;
            end
          end else begin
            state_q <= t_in ? StPutT : StENext;
          end
        end
        StMul: begin
          prod_q  <= mul_p;
          mstep_q <= mstep_q + 1'b1;
          case (mstep_q)
            2'd0: ;
            2'd1: acc_q <= NUMW'(prod_q);
            2'd2: acc_q <= acc_q - NUMW'(prod_q);
            default: begin
              acc_q   <= acc_q + NUMW'(prod_q);
              state_q <= StDivInit;
            end
          endcase
        end
        StDivInit: begin
          dvd_q   <= acc_mag;
          dvs_q   <= den_q_s[MW-1] ? MW'(-den_q_s) : MW'(den_q_s);
          neg_q   <= acc_q[NUMW-1] ^ den_q_s[MW-1];
          rem_q   <= '0;
          dcnt_q  <= DCW'(NUMW);
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q  <= qbit ? MW'(trial - {1'b0, dvs_q}) : MW'(trial);
          dvd_q  <= {dvd_q[NUMW-2:0], qbit};
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == DCW'(1)) begin
            state_q <= StDivFin;
          end
        end
        StDivFin: begin
          ip_o_q  <= q_sat;
          state_q <= StPutIp;
        end
        StPutIp: begin
          if (can_put) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= emit_t_q ? StPutT : StENext;
        end
        StPutT: begin
          if (can_put) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= StENext;
        end
        StENext: begin
          s_q   <= t_q;
          idx_q <= idx_q + 1'b1;
          state_q <= ({1'b0, idx_q} + 1'b1 == {1'b0, n_q}) ? StPEnd : StEFetch;
        end
        StPEnd: begin
          n_q     <= cnt_q;
          pass_q  <= pass_q + 1'b1;
          state_q <= (pass_q == 2'd3) ? StOStart : StPStart;
        end
        StOStart: begin
          idx_q    <= '0;
          rd_idx_q <= '0;
          if (n_q == '0) begin
            if (slot_free) begin
              out_q       <= '{out_x: '0, out_y: '0, last_out: 1'b1,
                               empty_res: 1'b1, overflow: ovf_q};
              state_q     <= StIdle;
            end
          end else begin
            state_q <= StORd;
          end
        end
        StORd: state_q <= StOWait;
        StOWait: begin
          if (slot_free) begin
            out_q <= '{out_x: src_pt.x, out_y: src_pt.y,
                       last_out: ({1'b0, idx_q} + 1'b1 == {1'b0, n_q}),
                       empty_res: 1'b0, overflow: ovf_q};
            idx_q       <= idx_q + 1'b1;
            rd_idx_q    <= idx_q + 1'b1;
            state_q     <= ({1'b0, idx_q} + 1'b1 == {1'b0, n_q}) ? StIdle : StORd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
